// ===== src/hbc_pkg.sv =====
// Shared types, constants and code functions for the Hamming(8,4) byte codec.
package hbc_pkg;

	localparam logic [7:0] Cw7Mask = 8'h7F;

	// Results one input item leaves behind; a single result sits in res1.
	typedef struct packed {
		logic [7:0] res0;
		logic [7:0] res1;
		logic       two;
		logic       blk_end;
		logic       odd;
	} pair_t;

	// Codeword bits 6..0: p1 p2 d3 p4 d2 d1 d0, bit 7 even parity over 6..0.
	function automatic logic [7:0] make_codeword(input logic [3:0] nib);
		logic q1;
		logic q2;
		logic q4;
		logic [6:0] low7;
		q1 = nib[3] ^ nib[2] ^ nib[0];
		q2 = nib[3] ^ nib[1] ^ nib[0];
		q4 = nib[2] ^ nib[1] ^ nib[0];
		low7 = {q1, q2, nib[3], q4, nib[2], nib[1], nib[0]};
		return {^low7, low7};
	endfunction

	// Single-error correction by syndrome; bit 7 is not checked.
	function automatic logic [3:0] fix_codeword(input logic [7:0] word);
		logic [6:0] w;
		logic [2:0] syn;
		w = 7'(word & Cw7Mask);
		syn[0] = w[6] ^ w[4] ^ w[2] ^ w[0];
		syn[1] = w[5] ^ w[4] ^ w[1] ^ w[0];
		syn[2] = w[3] ^ w[2] ^ w[1] ^ w[0];
		if (syn != 3'd0) begin
			w = w ^ (7'd1 << (3'd7 - syn));
		end
		return {w[4], w[2], w[1], w[0]};
	endfunction

endpackage

// ===== src/hbc_emit.sv =====
// Result stage and output register: sends one or two results per loaded item.
module hbc_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hbc_pkg::pair_t push_data,
	output logic          can_load,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    result_byte,
	output logic          last_of_run,
	output logic          block_done,
	output logic          odd_length
);
	import hbc_pkg::*;

	pair_t pair_s1;
	logic  valid_s1;
	logic  phase_s1;
	logic  emit;
	logic  final_emit;

	assign emit       = valid_s1 && (!out_valid || out_ready);
	assign final_emit = emit && (!pair_s1.two || phase_s1);
	assign can_load   = !valid_s1 || final_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			phase_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (push) begin
				valid_s1 <= 1'b1;
				phase_s1 <= 1'b0;
			end else if (final_emit) begin
				valid_s1 <= 1'b0;
			end else if (emit) begin
				phase_s1 <= 1'b1;
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pair_s1 <= push_data;
		end
		if (emit) begin
			if (final_emit) begin
				result_byte <= pair_s1.res1;
				last_of_run <= 1'b1;
				block_done  <= pair_s1.blk_end;
				odd_length  <= pair_s1.odd;
			end else begin
				result_byte <= pair_s1.res0;
				last_of_run <= 1'b0;
				block_done  <= 1'b0;
				odd_length  <= 1'b0;
			end
		end
	end

	// a new item only lands when the held one is on its last transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !final_emit) |-> !can_load)
		else $error("item loaded over a pending result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_run) |-> (!block_done && !odd_length))
		else $error("first half flagged as block end");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && odd_length) |-> (result_byte == 8'd0 && block_done && last_of_run))
		else $error("odd-length result malformed");

	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !final_emit) |=> (valid_s1 && phase_s1))
		else $error("second codeword lost");

endmodule

// ===== src/hamming_8_4_byte_codec.sv =====
// Top level of the Hamming(8,4) byte codec.
// Input channel (in_valid/in_ready): data_byte and block_end. Output channel
// (out_valid/out_ready): result_byte, last_of_run, block_done, odd_length.
// Config channel (cfg_valid/cfg_ready): mode, 0 encodes, 1 decodes; always ready.
// The user must write it only while the block is idle; the block does not enforce it.
// A write also drops a half-decoded pair. Encode: each byte gives two codewords,
// high nibble first, one per cycle unless out_ready stalls; the single output
// register sets the input to one byte per two codewords. Decode: one codeword per
// cycle unless stalled; every second one gives a byte, a block ending on an unpaired
// codeword gives a zero result with odd_length set. The result stage loads at the
// input transfer and feeds the output register whenever that register is free.
// A stalled receiver holds the output register; the result stage behind it
// then holds one more item, and in_ready drops until space frees up.
// Reset clears mode to encode, the held nibble, and all valid flags.
module hamming_8_4_byte_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       block_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_byte,
	output logic       last_of_run,
	output logic       block_done,
	output logic       odd_length,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       mode
);
	import hbc_pkg::*;

	logic       mode_q;
	logic [3:0] held_q;
	logic       half_q;
	logic       in_fire;
	logic       cfg_fire;
	logic       load_valid;
	logic       can_load;
	logic [3:0] nib;
	pair_t      load_data;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_ready  = can_load;
	assign in_fire   = in_valid && in_ready;
	assign nib       = fix_codeword(data_byte);

	always_comb begin
		load_valid        = 1'b0;
		load_data.res0    = make_codeword(data_byte[7:4]);
		load_data.res1    = make_codeword(data_byte[3:0]);
		load_data.two     = 1'b1;
		load_data.blk_end = block_end;
		load_data.odd     = 1'b0;
		if (!mode_q) begin
			load_valid = 1'b1;
		end else if (!half_q) begin
			load_valid     = block_end;
			load_data.res1 = 8'd0;
			load_data.two  = 1'b0;
			load_data.odd  = 1'b1;
		end else begin
			load_valid     = 1'b1;
			load_data.res1 = {held_q, nib};
			load_data.two  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			held_q <= 4'd0;
			half_q <= 1'b0;
		end else if (cfg_fire) begin
			mode_q <= mode;
			held_q <= 4'd0;
			half_q <= 1'b0;
		end else if (in_fire && mode_q) begin
			if (!half_q && !block_end) begin
				held_q <= nib;
				half_q <= 1'b1;
			end else begin
				held_q <= 4'd0;
				half_q <= 1'b0;
			end
		end
	end

	hbc_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (in_fire && load_valid),
		.push_data   (load_data),
		.can_load    (can_load),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_byte (result_byte),
		.last_of_run (last_of_run),
		.block_done  (block_done),
		.odd_length  (odd_length)
	);

	// pairing state only lives in decode mode
	assert property (@(posedge clk) disable iff (!arst_n)
		!mode_q |-> (!half_q && held_q == 4'd0))
		else $error("pair state held in encode mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode_q && half_q) |=> !half_q)
		else $error("pair not closed by second codeword");

endmodule
